[rtl/tfbs_pkg.sv]
// Package with the item and result types and the fixed constants of the baseline trainer.
`timescale 1ns / 1ps

package tfbs_pkg;

  // Number of configuration registers and the width of the APB address.
  localparam int NumRegs = 8;
  localparam int PaddrW = 6;

  // Store geometry. The id and day fields are exactly as wide as their stores are deep.
  localparam int Users = 1024;
  localparam int Movies = 4096;
  localparam int Days = 2048;
  localparam int DayBins = 30;
  localparam int FreqBuckets = 5;
  localparam int BinDays = 75;

  // Day bin by reciprocal multiplication; exact for every 11-bit day.
  localparam int BinShift = 17;
  localparam int BinRecip = (2 ** BinShift + BinDays - 1) / BinDays;

  // Register indexes, one per store, in update order.
  localparam logic [2:0] RegUserBias    = 3'd0;
  localparam logic [2:0] RegUserDrift   = 3'd1;
  localparam logic [2:0] RegUserDayBias = 3'd2;
  localparam logic [2:0] RegMovieBias   = 3'd3;
  localparam logic [2:0] RegMovieBin    = 3'd4;
  localparam logic [2:0] RegUserScale   = 3'd5;
  localparam logic [2:0] RegUserDayScl  = 3'd6;
  localparam logic [2:0] RegMovieFreq   = 3'd7;

  // Global mean and unity in Q8.24.
  localparam logic signed [31:0] MuQ24 = 32'sd60557633;
  localparam logic signed [31:0] OneQ24 = 32'sd16777216;

  // Smallest day counts that reach frequency buckets one to four; the fifth also maps to bucket four.
  localparam logic [15:0] FreqThr1 = 16'd7;
  localparam logic [15:0] FreqThr2 = 16'd46;
  localparam logic [15:0] FreqThr3 = 16'd309;
  localparam logic [15:0] FreqThr4 = 16'd2089;
  localparam logic [15:0] FreqThr5 = 16'd14117;

  // Input item.
  typedef struct packed {
    logic        func;
    logic [9:0]  user_id;
    logic [11:0] movie_id;
    logic [10:0] day_index;
    logic [2:0]  rating;
    logic [14:0] user_mean_day;
    logic [15:0] day_rating_count;
  } item_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] prediction;
    logic signed [31:0] residual;
  } result_t;

endpackage

[rtl/time_freq_baseline_sgd.sv]
// Time and frequency baseline predictor with SGD training over eight on-chip stores.
// A predict item goes from the accepting edge to the result beat without the SGD updates of a
// train item; the fifth-root search resolves 29 bits, one bit per search step.
// Throughput: one item at a time; a new item can start in the cycle of the result beat.
// Reset: a clearing pass writes every store entry, one address a cycle, over the depth of the
// deepest store (2097152 entries); busy stays high. The receiver cannot stall the result under done_o.
`timescale 1ns / 1ps

module time_freq_baseline_sgd (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  tfbs_pkg::item_t            item_i,
  output tfbs_pkg::result_t          result_o,
  output logic                       done_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tfbs_pkg::PaddrW-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  // Store depths and address widths.
  localparam longint unsigned DUser = longint'(tfbs_pkg::Users);
  localparam longint unsigned DUd = longint'(tfbs_pkg::Users) * longint'(tfbs_pkg::Days);
  localparam longint unsigned DMov = longint'(tfbs_pkg::Movies);
  localparam longint unsigned DBin = longint'(tfbs_pkg::Movies) * longint'(tfbs_pkg::DayBins);
  localparam longint unsigned DFrq = longint'(tfbs_pkg::Movies)
                                     * longint'(tfbs_pkg::FreqBuckets);
  localparam longint unsigned DMax1 = (DUd > DBin) ? DUd : DBin;
  localparam longint unsigned MaxDepth = (DMax1 > DFrq) ? DMax1 : DFrq;
  localparam int AW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int CW = $clog2(MaxDepth + 1);

  // State codes.
  localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,   S_IDX = 5'd2;
  localparam logic [4:0] S_ADDR = 5'd4,   S_DVINIT = 5'd5, S_DVCAND = 5'd6, S_DVMUL = 5'd7;
  localparam logic [4:0] S_DVCMP = 5'd8,  S_RD = 5'd9,     S_LAT = 5'd10,  S_SUMS = 5'd11;
  localparam logic [4:0] S_MAU = 5'd12,   S_MSS = 5'd13,   S_PRED = 5'd14, S_EUM = 5'd15;
  localparam logic [4:0] S_GAU = 5'd16,   S_GBM = 5'd17,   S_GSET = 5'd18, S_PEN = 5'd19;
  localparam logic [4:0] S_INN = 5'd20,   S_ETA = 5'd21,   S_UPW = 5'd22,  S_SB2 = 5'd23;
  localparam logic [4:0] S_MCU = 5'd24,   S_GCU = 5'd25,   S_WB = 5'd26,   S_DONE = 5'd27;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Depth of the store that belongs to a register index.
  function automatic longint unsigned store_depth(input int i);
    unique case (3'(i)) inside
      tfbs_pkg::RegUserBias, tfbs_pkg::RegUserDrift, tfbs_pkg::RegUserScale: return DUser;
      tfbs_pkg::RegUserDayBias, tfbs_pkg::RegUserDayScl: return DUd;
      tfbs_pkg::RegMovieBias: return DMov;
      tfbs_pkg::RegMovieBin: return DBin;
      default: return DFrq;
    endcase
  endfunction

  logic [4:0]         state_q;
  logic [CW-1:0]      clr_q;
  logic [63:0]        cfg_q [8];
  tfbs_pkg::item_t    item_q;
  tfbs_pkg::result_t  res_q;
  logic               done_q;

  // Reduced indices and addresses.
  logic [9:0]         u_q;
  logic [11:0]        m_q;
  logic [10:0]        t_q;
  logic [5:0]         bin_q;
  logic [21:0]        bin_prod;
  logic [AW-1:0]      a_user_q, a_ud_q, a_mov_q, a_bin_q, a_frq_q;
  logic [3:0]         bucket;

  // Deviation search registers.
  logic [31:0]        n_q;
  logic               dneg_q;
  logic [28:0]        y_q, c_q, carry_q;
  logic [4:0]         bit_q;
  logic [144:0]       p_q;
  logic [1:0]         pass_q;
  logic [2:0]         limb_q;
  logic [57:0]        lprod;
  logic signed [29:0] dv_q;
  logic signed [16:0] dlt;
  logic [15:0]        dabs;

  // Arithmetic registers.
  logic signed [31:0] x_q [8];
  logic signed [41:0] g_q [8];
  logic signed [31:0] sb_q, sc_q, pred_q, eum_q, inner_q;
  logic signed [41:0] term_q;
  logic signed [65:0] prod_q;
  logic signed [32:0] mul_a, mul_b;
  logic [2:0]         k_q;

  // Memory ports.
  logic [AW-1:0]      mem_addr [8];
  logic               mem_we [8];
  logic [31:0]        mem_wd [8];
  logic [31:0]        mem_rd [8];

  assign busy = (state_q != S_IDLE);
  assign result_o = res_q;
  assign done_o = done_q;
  assign pready = 1'b1;
  assign prdata = cfg_q[paddr[5:3]];

  // Day bin quotient by a constant reciprocal.
  assign bin_prod = 22'(item_q.day_index) * 22'(tfbs_pkg::BinRecip);

  // Frequency bucket from the day count, held at the last bucket.
  always_comb begin
    logic [3:0] b;
    b = 4'd0;
    if (item_q.day_rating_count >= tfbs_pkg::FreqThr1) b = 4'd1;
    if (item_q.day_rating_count >= tfbs_pkg::FreqThr2) b = 4'd2;
    if (item_q.day_rating_count >= tfbs_pkg::FreqThr3) b = 4'd3;
    if (item_q.day_rating_count >= tfbs_pkg::FreqThr4) b = 4'd4;
    if (item_q.day_rating_count >= tfbs_pkg::FreqThr5) b = 4'd5;
    if (b > 4'(tfbs_pkg::FreqBuckets - 1)) b = 4'(tfbs_pkg::FreqBuckets - 1);
    bucket = b;
  end

  // Signed day offset and one limb step of the fifth-power product.
  assign dlt = $signed({2'b0, t_q, 4'b0}) - $signed({2'b0, item_q.user_mean_day});
  assign dabs = dlt[16] ? 16'(-dlt) : dlt[15:0];
  assign lprod = 58'(p_q[limb_q*29 +: 29]) * 58'(c_q) + 58'(carry_q);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MAU: begin
        mul_a = 33'(x_q[1]);
        mul_b = 33'(dv_q);
      end
      S_MSS: begin
        mul_a = 33'(sb_q);
        mul_b = 33'(sc_q);
      end
      S_GAU: begin
        mul_a = 33'(eum_q);
        mul_b = 33'(dv_q);
      end
      S_GBM: begin
        mul_a = 33'(eum_q);
        mul_b = 33'(sc_q);
      end
      S_MCU: begin
        mul_a = 33'(eum_q);
        mul_b = 33'(sb_q);
      end
      S_PEN: begin
        mul_a = $signed({1'b0, cfg_q[k_q][31:0]});
        mul_b = 33'(sat32(72'(x_q[k_q]) -
                ((k_q == tfbs_pkg::RegUserScale) ? 72'(tfbs_pkg::OneQ24) : 72'sd0)));
      end
      S_ETA: begin
        mul_a = $signed({1'b0, cfg_q[k_q][63:32]});
        mul_b = 33'(inner_q);
      end
      default: ;
    endcase
  end

  // Memory address, write enable and write data: clearing pass or write-back.
  always_comb begin
    mem_addr[0] = a_user_q;
    mem_addr[1] = a_user_q;
    mem_addr[2] = a_ud_q;
    mem_addr[3] = a_mov_q;
    mem_addr[4] = a_bin_q;
    mem_addr[5] = a_user_q;
    mem_addr[6] = a_ud_q;
    mem_addr[7] = a_frq_q;
    for (int i = 0; i < 8; i++) begin
      mem_we[i] = (state_q == S_WB);
      mem_wd[i] = x_q[i];
      if (state_q == S_CLEAR) begin
        mem_addr[i] = clr_q[AW-1:0];
        mem_we[i] = (64'(clr_q) < store_depth(i));
        mem_wd[i] = (3'(i) == tfbs_pkg::RegUserScale) ? tfbs_pkg::OneQ24 : 32'd0;
      end
    end
  end

  // The eight stores, each a single-port memory with a registered read.
  for (genvar gi = 0; gi < 8; gi++) begin : g_mem
    localparam longint unsigned Dep = store_depth(gi);
    localparam int MAW = (Dep > 1) ? $clog2(Dep) : 1;
    logic [31:0] mem [Dep];
    always_ff @(posedge clk_i) begin
      if (mem_we[gi]) mem[mem_addr[gi][MAW-1:0]] <= mem_wd[gi];
      mem_rd[gi] <= mem[mem_addr[gi][MAW-1:0]];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) cfg_q[i] <= '0;
    end else if (psel && penable && pwrite) begin
      cfg_q[paddr[5:3]] <= pwdata;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      done_q <= 1'b0;
      item_q <= '0;
      res_q <= '0;
      u_q <= '0;
      m_q <= '0;
      t_q <= '0;
      bin_q <= '0;
      a_user_q <= '0;
      a_ud_q <= '0;
      a_mov_q <= '0;
      a_bin_q <= '0;
      a_frq_q <= '0;
      n_q <= '0;
      dneg_q <= 1'b0;
      y_q <= '0;
      c_q <= '0;
      carry_q <= '0;
      bit_q <= '0;
      p_q <= '0;
      pass_q <= '0;
      limb_q <= '0;
      dv_q <= '0;
      for (int i = 0; i < 8; i++) begin
        x_q[i] <= '0;
        g_q[i] <= '0;
      end
      sb_q <= '0;
      sc_q <= '0;
      pred_q <= '0;
      eum_q <= '0;
      inner_q <= '0;
      term_q <= '0;
      prod_q <= '0;
      k_q <= '0;
    end else begin
      prod_q <= 66'(mul_a * mul_b);
      done_q <= (state_q == S_DONE);
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CW'(MaxDepth - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            item_q <= item_i;
            state_q <= S_IDX;
          end
        end
        // Indices; the day bin is held at the last bin.
        S_IDX: begin
          u_q <= item_q.user_id;
          m_q <= item_q.movie_id;
          t_q <= item_q.day_index;
          if (6'(bin_prod[21:tfbs_pkg::BinShift]) >= 6'(tfbs_pkg::DayBins - 1)) begin
            bin_q <= 6'(tfbs_pkg::DayBins - 1);
          end else begin
            bin_q <= 6'(bin_prod[21:tfbs_pkg::BinShift]);
          end
          state_q <= S_ADDR;
        end
        // Flat store addresses.
        S_ADDR: begin
          a_user_q <= AW'(u_q);
          a_mov_q <= AW'(m_q);
          a_ud_q <= AW'(longint'(u_q) * longint'(tfbs_pkg::Days) + longint'(t_q));
          a_bin_q <= AW'(longint'(m_q) * longint'(tfbs_pkg::DayBins) + longint'(bin_q));
          a_frq_q <= AW'(longint'(m_q) * longint'(tfbs_pkg::FreqBuckets) + longint'(bucket));
          state_q <= S_DVINIT;
        end
        // Fifth-root search: largest y with y^5 <= a^2 * 2^112.
        S_DVINIT: begin
          n_q <= 32'(dabs) * 32'(dabs);
          dneg_q <= dlt[16];
          y_q <= '0;
          bit_q <= 5'd28;
          state_q <= S_DVCAND;
        end
        S_DVCAND: begin
          c_q <= y_q | (29'd1 << bit_q);
          p_q <= {116'd0, y_q | (29'd1 << bit_q)};
          pass_q <= '0;
          limb_q <= '0;
          carry_q <= '0;
          state_q <= S_DVMUL;
        end
        S_DVMUL: begin
          if (limb_q == 3'(pass_q)) begin
            // The top limb of a pass also takes the carry out.
            p_q[limb_q*29 +: 58] <= lprod;
            carry_q <= '0;
            limb_q <= '0;
            pass_q <= pass_q + 1'b1;
            if (pass_q == 2'd3) state_q <= S_DVCMP;
          end else begin
            p_q[limb_q*29 +: 29] <= lprod[28:0];
            carry_q <= lprod[57:29];
            limb_q <= limb_q + 1'b1;
          end
        end
        S_DVCMP: begin
          if (p_q <= {1'b0, n_q, 112'd0}) y_q <= c_q;
          if (bit_q == 5'd0) begin
            dv_q <= dneg_q ? -$signed({1'b0, ((p_q <= {1'b0, n_q, 112'd0}) ? c_q : y_q)})
                           : $signed({1'b0, ((p_q <= {1'b0, n_q, 112'd0}) ? c_q : y_q)});
            state_q <= S_RD;
          end else begin
            bit_q <= bit_q - 1'b1;
            state_q <= S_DVCAND;
          end
        end
        S_RD: state_q <= S_LAT;
        S_LAT: begin
          for (int i = 0; i < 8; i++) x_q[i] <= mem_rd[i];
          state_q <= S_SUMS;
        end
        S_SUMS: begin
          sb_q <= sat32(72'(x_q[3]) + 72'(x_q[4]));
          sc_q <= sat32(72'(x_q[5]) + 72'(x_q[6]));
          state_q <= S_MAU;
        end
        S_MAU: state_q <= S_MSS;
        S_MSS: begin
          term_q <= 42'(prod_q >>> 24);
          state_q <= S_PRED;
        end
        S_PRED: begin
          pred_q <= sat32(72'(tfbs_pkg::MuQ24) + 72'(x_q[0]) + 72'(term_q) + 72'(x_q[2])
                          + 72'(prod_q >>> 24) + 72'(x_q[7]));
          state_q <= S_EUM;
        end
        S_EUM: begin
          if (item_q.func) begin
            eum_q <= '0;
            state_q <= S_DONE;
          end else begin
            eum_q <= sat32($signed({45'd0, item_q.rating, 24'd0}) - 72'(pred_q));
            state_q <= S_GAU;
          end
        end
        S_GAU: state_q <= S_GBM;
        S_GBM: begin
          g_q[1] <= 42'(prod_q >>> 24);
          state_q <= S_GSET;
        end
        S_GSET: begin
          g_q[3] <= 42'(prod_q >>> 24);
          g_q[4] <= 42'(prod_q >>> 24);
          g_q[0] <= 42'(eum_q);
          g_q[2] <= 42'(eum_q);
          g_q[7] <= 42'(eum_q);
          k_q <= tfbs_pkg::RegUserBias;
          state_q <= S_PEN;
        end
        // One regularized update: penalty, clamp, step.
        S_PEN: state_q <= S_INN;
        S_INN: begin
          inner_q <= sat32(72'(g_q[k_q]) - 72'(prod_q >>> 28));
          state_q <= S_ETA;
        end
        S_ETA: state_q <= S_UPW;
        S_UPW: begin
          x_q[k_q] <= sat32(72'(x_q[k_q]) + 72'(prod_q >>> 32));
          if (k_q == tfbs_pkg::RegMovieBin) state_q <= S_SB2;
          else if (k_q == tfbs_pkg::RegMovieFreq) state_q <= S_WB;
          else begin
            k_q <= k_q + 1'b1;
            state_q <= S_PEN;
          end
        end
        // Scale gradients use the updated movie biases.
        S_SB2: begin
          sb_q <= sat32(72'(x_q[3]) + 72'(x_q[4]));
          state_q <= S_MCU;
        end
        S_MCU: state_q <= S_GCU;
        S_GCU: begin
          g_q[5] <= 42'(prod_q >>> 24);
          g_q[6] <= 42'(prod_q >>> 24);
          k_q <= tfbs_pkg::RegUserScale;
          state_q <= S_PEN;
        end
        S_WB: state_q <= S_DONE;
        S_DONE: begin
          res_q.prediction <= pred_q;
          res_q.residual <= eum_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
